@@ rtl/segment_point_constraint_assert.svh @@
// Assertion macros for the segment point constraint checker.
// Needs nothing else; included by the checker file.
`ifndef SEGMENT_POINT_CONSTRAINT_ASSERT_SVH
`define SEGMENT_POINT_CONSTRAINT_ASSERT_SVH

// Plain clocked assertion with reset disable.
`define SPC_ASSERT(name, ck, rn, prop) \
    name: assert property (@(posedge ck) disable iff (!(rn)) prop) \
        else $error("segment_point_constraint assertion failed");

// Implication shorthand built on the one above.
`define SPC_ASSERT_IMP(name, ck, rn, ante, cons) \
    `SPC_ASSERT(name, ck, rn, (ante) |-> (cons))

`endif

@@ rtl/spc_pkg.sv @@
// Package for the segment point constraint block: widths, op codes, sideband type.
// No dependencies.
`default_nettype none
package spc_pkg;
    localparam int CW  = 24;            // coordinate width
    localparam int DFW = CW + 1;        // difference width
    localparam int SQW = 2 * DFW;       // product width
    localparam int L2W = 50;            // squared length width
    localparam int NMW = 51;            // signed dot product width
    localparam int EPW = 52;            // epsilon width
    localparam int HW  = 25;            // num half width
    localparam int PPW = CW + HW;       // partial product width
    localparam int QW  = 26;            // quotient width
    localparam int DW  = L2W + 1;       // divisor width (2*L2)
    localparam int RW  = DW + QW;       // dividend / remainder width

    localparam logic [1:0] OP_END1  = 2'd0;
    localparam logic [1:0] OP_END2  = 2'd1;
    localparam logic [1:0] OP_POINT = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [EPW-1:0] EPS_RESET = EPW'(1);

    typedef logic signed [CW-1:0] coord_t;
    typedef logic [RW-1:0]        rem_t;
    typedef logic [QW-1:0]        quo_t;

    typedef struct packed {
        logic       sat;
        logic [1:0] cvar;
        logic       proj;
        logic [2:0] neg;
        coord_t     base_x;
        coord_t     base_y;
        coord_t     base_z;
    } side_t;
endpackage
`default_nettype wire

@@ rtl/spc_if.sv @@
// Handshake interfaces for the segment point constraint block.
// Uses spc_pkg for widths.
`default_nettype none
interface spc_in_if;
    import spc_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    coord_t     end1_x, end1_y, end1_z;
    coord_t     end2_x, end2_y, end2_z;
    coord_t     point_x, point_y, point_z;
    modport source (output valid, operation, end1_x, end1_y, end1_z, end2_x, end2_y,
                    end2_z, point_x, point_y, point_z, input ready);
    modport sink (input valid, operation, end1_x, end1_y, end1_z, end2_x, end2_y,
                  end2_z, point_x, point_y, point_z, output ready);
endinterface

interface spc_out_if;
    import spc_pkg::*;
    logic       valid;
    logic       ready;
    logic       satisfied;
    logic [1:0] changed_var;
    coord_t     new_x, new_y, new_z;
    modport source (output valid, satisfied, changed_var, new_x, new_y, new_z,
                    input ready);
    modport sink (input valid, satisfied, changed_var, new_x, new_y, new_z,
                  output ready);
endinterface

interface spc_cfg_if;
    import spc_pkg::*;
    logic           valid;
    logic           ready;
    logic [EPW-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/segment_point_constraint.sv @@
// Pipeline from input transfer to result valid: 6 arithmetic stages, 26 divider
// stages, output register. Throughput: one item per cycle; the whole
// pipeline holds while the output register is full and not taken.
// Reset: rst_n async active low clears all valid bits, epsilon returns to 1.
// Depends on spc_pkg, spc_if.sv and spc_divider.
`default_nettype none
module segment_point_constraint (
    input  wire logic clk,
    input  wire logic rst_n,
    spc_in_if.sink    req,
    spc_out_if.source rsp,
    spc_cfg_if.sink   cfg
);
    import spc_pkg::*;

    typedef logic signed [DFW-1:0] diff_t;

    logic           en;
    logic [EPW-1:0] eps_reg;

    // stage 1: differences
    logic       v1_reg;
    logic [1:0] op1_reg;
    coord_t     e1_1_reg [3], e2_1_reg [3], p_1_reg [3];
    diff_t      d1_reg [3], pa1_reg [3], pe1_reg [3];
    // stage 2: products
    logic              v2_reg;
    logic [1:0]        op2_reg;
    coord_t            e1_2_reg [3], e2_2_reg [3], p_2_reg [3];
    logic [CW-1:0]     adv2_reg [3];
    logic [2:0]        neg2_reg;
    logic [SQW-1:0]    dd2_reg [3], aa2_reg [3];
    logic signed [SQW-1:0] pd2_reg [3];
    // stage 3: sums
    logic              v3_reg;
    logic [1:0]        op3_reg;
    coord_t            e1_3_reg [3], e2_3_reg [3], p_3_reg [3];
    logic [CW-1:0]     adv3_reg [3];
    logic [2:0]        neg3_reg;
    logic [L2W-1:0]    l2_3_reg, dst3_reg;
    logic signed [NMW-1:0] num3_reg;
    // stage 4: decision
    logic              v4_reg;
    side_t             s4_reg;
    logic [CW-1:0]     adv4_reg [3];
    logic [L2W-1:0]    l2_4_reg;
    logic [HW-1:0]     nlo4_reg, nhi4_reg;
    side_t             s4_next;
    // stage 5: partial products
    logic              v5_reg;
    side_t             s5_reg;
    logic [L2W-1:0]    l2_5_reg;
    logic [PPW-1:0]    plo5_reg [3], phi5_reg [3];
    // stage 6: dividend
    logic              v6_reg;
    side_t             s6_reg;
    logic [DW-1:0]     den6_reg;
    rem_t              n6_reg [3];
    // divider and output
    logic              dv_valid;
    side_t             dv_side;
    quo_t              dv_quo [3];
    logic              ov_reg;
    logic              osat_reg;
    logic [1:0]        ocv_reg;
    coord_t            onew_reg [3];
    coord_t            onew_next [3];

    assign en        = !ov_reg || rsp.ready;
    assign req.ready = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (cfg.valid)
            eps_reg <= cfg.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            ov_reg <= dv_valid;
        end
    end

    coord_t in_e1 [3], in_e2 [3], in_p [3];
    assign in_e1 = '{req.end1_x, req.end1_y, req.end1_z};
    assign in_e2 = '{req.end2_x, req.end2_y, req.end2_z};
    assign in_p  = '{req.point_x, req.point_y, req.point_z};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= req.operation;
            for (int i = 0; i < 3; i++)
            begin
                e1_1_reg[i] <= in_e1[i];
                e2_1_reg[i] <= in_e2[i];
                p_1_reg[i]  <= in_p[i];
                d1_reg[i]   <= DFW'(in_e2[i]) - DFW'(in_e1[i]);
                pe1_reg[i]  <= DFW'(in_p[i]) - DFW'(in_e1[i]);
                pa1_reg[i]  <= (req.operation == OP_END2) ? DFW'(in_p[i]) - DFW'(in_e2[i])
                                                          : DFW'(in_p[i]) - DFW'(in_e1[i]);
            end

            op2_reg <= op1_reg;
            for (int i = 0; i < 3; i++)
            begin
                e1_2_reg[i] <= e1_1_reg[i];
                e2_2_reg[i] <= e2_1_reg[i];
                p_2_reg[i]  <= p_1_reg[i];
                neg2_reg[i] <= d1_reg[i][DFW-1];
                adv2_reg[i] <= d1_reg[i][DFW-1] ? CW'(-d1_reg[i]) : CW'(d1_reg[i]);
                dd2_reg[i]  <= SQW'(d1_reg[i] * d1_reg[i]);
                aa2_reg[i]  <= SQW'(pa1_reg[i] * pa1_reg[i]);
                pd2_reg[i]  <= pe1_reg[i] * d1_reg[i];
            end

            op3_reg  <= op2_reg;
            neg3_reg <= neg2_reg;
            for (int i = 0; i < 3; i++)
            begin
                e1_3_reg[i] <= e1_2_reg[i];
                e2_3_reg[i] <= e2_2_reg[i];
                p_3_reg[i]  <= p_2_reg[i];
                adv3_reg[i] <= adv2_reg[i];
            end
            l2_3_reg <= L2W'(dd2_reg[0]) + L2W'(dd2_reg[1]) + L2W'(dd2_reg[2]);
            dst3_reg <= L2W'(aa2_reg[0]) + L2W'(aa2_reg[1]) + L2W'(aa2_reg[2]);
            num3_reg <= NMW'(pd2_reg[0]) + NMW'(pd2_reg[1]) + NMW'(pd2_reg[2]);

            s4_reg   <= s4_next;
            l2_4_reg <= l2_3_reg;
            nlo4_reg <= num3_reg[HW-1:0];
            nhi4_reg <= num3_reg[2*HW-1:HW];
            for (int i = 0; i < 3; i++)
                adv4_reg[i] <= adv3_reg[i];

            s5_reg   <= s4_reg;
            l2_5_reg <= l2_4_reg;
            for (int i = 0; i < 3; i++)
            begin
                plo5_reg[i] <= PPW'(adv4_reg[i]) * PPW'(nlo4_reg);
                phi5_reg[i] <= PPW'(adv4_reg[i]) * PPW'(nhi4_reg);
            end

            s6_reg   <= s5_reg;
            den6_reg <= {l2_5_reg, 1'b0};
            for (int i = 0; i < 3; i++)
                n6_reg[i] <= ((RW'(phi5_reg[i]) << HW) + RW'(plo5_reg[i])) * RW'(2)
                             + RW'(l2_5_reg);

            osat_reg <= dv_side.sat;
            ocv_reg  <= dv_side.cvar;
            for (int i = 0; i < 3; i++)
                onew_reg[i] <= onew_next[i];
        end
    end

    // result selection
    always_comb
    begin
        s4_next = '0;
        unique case (op3_reg)
            OP_END1, OP_END2:
            begin
                if (l2_3_reg < dst3_reg)
                begin
                    s4_next.sat    = 1'b1;
                    s4_next.cvar   = op3_reg;
                    s4_next.base_x = p_3_reg[0];
                    s4_next.base_y = p_3_reg[1];
                    s4_next.base_z = p_3_reg[2];
                end
            end
            OP_POINT:
            begin
                s4_next.sat  = 1'b1;
                s4_next.cvar = OP_POINT;
                s4_next.neg  = neg3_reg;
                priority if (EPW'(l2_3_reg) < eps_reg ||
                             (!num3_reg[NMW-1] && NMW'(l2_3_reg) <= num3_reg))
                begin
                    s4_next.base_x = e2_3_reg[0];
                    s4_next.base_y = e2_3_reg[1];
                    s4_next.base_z = e2_3_reg[2];
                end
                else if (num3_reg[NMW-1] || num3_reg == '0)
                begin
                    s4_next.base_x = e1_3_reg[0];
                    s4_next.base_y = e1_3_reg[1];
                    s4_next.base_z = e1_3_reg[2];
                end
                else
                begin
                    s4_next.proj   = 1'b1;
                    s4_next.base_x = e1_3_reg[0];
                    s4_next.base_y = e1_3_reg[1];
                    s4_next.base_z = e1_3_reg[2];
                end
            end
            OP_NONE:
            begin
                s4_next = '0;
            end
            default:
            begin
                s4_next = '0;
            end
        endcase
    end

    spc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .in_side   (s6_reg),
        .in_num    (n6_reg),
        .in_den    (den6_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo)
    );

    coord_t dv_base [3];
    assign dv_base = '{dv_side.base_x, dv_side.base_y, dv_side.base_z};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [QW+1:0] sum;
            sum = (QW+2)'(dv_base[i]);
            if (dv_side.proj)
                sum = dv_side.neg[i] ? sum - (QW+2)'(dv_quo[i]) : sum + (QW+2)'(dv_quo[i]);
            priority if (sum > (QW+2)'(signed'({1'b0, {(CW-1){1'b1}}})))
                onew_next[i] = {1'b0, {(CW-1){1'b1}}};
            else if (sum < (QW+2)'(signed'({1'b1, {(CW-1){1'b0}}})))
                onew_next[i] = {1'b1, {(CW-1){1'b0}}};
            else
                onew_next[i] = sum[CW-1:0];
        end
    end

    assign rsp.valid       = ov_reg;
    assign rsp.satisfied   = osat_reg;
    assign rsp.changed_var = ocv_reg;
    assign rsp.new_x       = onew_reg[0];
    assign rsp.new_y       = onew_reg[1];
    assign rsp.new_z       = onew_reg[2];
endmodule
`default_nettype wire

@@ rtl/spc_divider.sv @@
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on spc_pkg.
`default_nettype none
module spc_divider (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire spc_pkg::side_t  in_side,
    input  wire spc_pkg::rem_t   in_num [3],
    input  wire logic [spc_pkg::DW-1:0] in_den,
    output logic                 out_valid,
    output spc_pkg::side_t       out_side,
    output spc_pkg::quo_t        out_quo [3]
);
    import spc_pkg::*;

    logic          v_reg [QW];
    side_t         s_reg [QW];
    logic [DW-1:0] d_reg [QW];
    rem_t          r_reg [QW][3];
    quo_t          q_reg [QW][3];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic          v_in;
        side_t         s_in;
        logic [DW-1:0] d_in;
        rem_t          r_in [3];
        quo_t          q_in [3];
        rem_t          r_next [3];
        quo_t          q_next [3];

        if (j == 0) begin : g_first
            assign v_in = in_valid;
            assign s_in = in_side;
            assign d_in = in_den;
            for (genvar l = 0; l < 3; l++) begin : g_l
                assign r_in[l] = in_num[l];
                assign q_in[l] = '0;
            end
        end else begin : g_rest
            assign v_in = v_reg[j-1];
            assign s_in = s_reg[j-1];
            assign d_in = d_reg[j-1];
            for (genvar l = 0; l < 3; l++) begin : g_l
                assign r_in[l] = r_reg[j-1][l];
                assign q_in[l] = q_reg[j-1][l];
            end
        end

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic [RW:0] trial;
                trial = {1'b0, r_in[l]} - {1'b0, (RW'(d_in) << (QW - 1 - j))};
                if (!trial[RW])
                begin
                    r_next[l] = trial[RW-1:0];
                    q_next[l] = {q_in[l][QW-2:0], 1'b1};
                end
                else
                begin
                    r_next[l] = r_in[l];
                    q_next[l] = {q_in[l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[j] <= s_in;
                d_reg[j] <= d_in;
                for (int l = 0; l < 3; l++)
                begin
                    r_reg[j][l] <= r_next[l];
                    q_reg[j][l] <= q_next[l];
                end
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_side  = s_reg[QW-1];
    for (genvar l = 0; l < 3; l++) begin : g_out
        assign out_quo[l] = q_reg[QW-1][l];
    end
endmodule
`default_nettype wire

@@ rtl/spc_checker.sv @@
// Port-level checks for segment_point_constraint, bound to the top level.
// Depends on segment_point_constraint_assert.svh.
`default_nettype none
`include "segment_point_constraint_assert.svh"
module spc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        out_sat,
    input wire logic [1:0]  out_cvar,
    input wire logic [23:0] out_x,
    input wire logic [23:0] out_y,
    input wire logic [23:0] out_z
);
    `SPC_ASSERT_IMP(a_hold, clk, rst_n, out_valid && !out_ready, ##1 out_valid && $stable(out_x))
    `SPC_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && !out_sat, out_cvar == 2'd0 && out_x == 24'd0 && out_y == 24'd0 && out_z == 24'd0)
    `SPC_ASSERT_IMP(a_cvar_range, clk, rst_n, out_valid && out_sat, out_cvar != 2'd3)
endmodule

bind segment_point_constraint spc_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_sat   (rsp.satisfied),
    .out_cvar  (rsp.changed_var),
    .out_x     (rsp.new_x),
    .out_y     (rsp.new_y),
    .out_z     (rsp.new_z)
);
`default_nettype wire

@@ tb/sv/segment_point_constraint_tb.sv @@
// Testbench for segment_point_constraint: directed table then random queries,
// checked against a built-in projection/length predictor. Needs spc_pkg, spc_if.sv, RTL.
`timescale 1ns / 100ps
`default_nettype none
module segment_point_constraint_tb;
    import spc_pkg::*;

    typedef struct packed {
        logic [1:0] op;
        coord_t e1x, e1y, e1z, e2x, e2y, e2z, px, py, pz;
    } query_t;

    typedef struct packed {
        logic       sat;
        logic [1:0] cvar;
        coord_t     nx, ny, nz;
    } answer_t;

    typedef struct {
        query_t  q;
        bit      known;
        answer_t a;
    } row_t;

    logic clk;
    logic rst_n;
    spc_in_if  req();
    spc_out_if rsp();
    spc_cfg_if cfg();

    segment_point_constraint DUT (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg));

    localparam int LATENCY = 33;
    localparam int STALL_LIMIT = 5000;

    logic [EPW-1:0] eps_model;
    answer_t        pending_answers[$];
    int             mismatches;
    int             idle_cycles;
    bit             timed_out;
    bit             out_gaps;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sq(longint v);
        return v * v;
    endfunction

    // round(|dv| * num / l2), halves away from zero
    function automatic longint project_offset(longint adv, longint num, longint l2);
        logic [127:0] prod;
        prod = 128'(adv) * 128'(num);
        prod = (prod << 1) + 128'(l2);
        return longint'(prod / (128'(l2) << 1));
    endfunction

    function automatic coord_t sat24(longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return coord_t'(v);
    endfunction

    function automatic answer_t solve_query(query_t q);
        answer_t r;
        longint e1[3], e2[3], p[3], a[3], b[3], d[3];
        longint seg, dst, l2, num, off;
        r = '0;
        e1[0] = q.e1x; e1[1] = q.e1y; e1[2] = q.e1z;
        e2[0] = q.e2x; e2[1] = q.e2y; e2[2] = q.e2z;
        p[0] = q.px; p[1] = q.py; p[2] = q.pz;
        if (q.op == OP_END1 || q.op == OP_END2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a[i] = (q.op == OP_END1) ? e1[i] : e2[i];
                b[i] = (q.op == OP_END1) ? e2[i] : e1[i];
            end
            seg = sq(b[0] - a[0]) + sq(b[1] - a[1]) + sq(b[2] - a[2]);
            dst = sq(p[0] - a[0]) + sq(p[1] - a[1]) + sq(p[2] - a[2]);
            if (seg < dst)
            begin
                r.sat = 1'b1;
                r.cvar = q.op;
                r.nx = q.px; r.ny = q.py; r.nz = q.pz;
            end
        end
        else if (q.op == OP_POINT)
        begin
            r.sat = 1'b1;
            r.cvar = OP_POINT;
            for (int i = 0; i < 3; i++) d[i] = e2[i] - e1[i];
            l2 = sq(d[0]) + sq(d[1]) + sq(d[2]);
            num = 0;
            for (int i = 0; i < 3; i++) num += (p[i] - e1[i]) * d[i];
            if (64'(l2) < 64'(eps_model) || num >= l2)
            begin
                r.nx = q.e2x; r.ny = q.e2y; r.nz = q.e2z;
            end
            else if (num <= 0)
            begin
                r.nx = q.e1x; r.ny = q.e1y; r.nz = q.e1z;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    off = project_offset(d[i] < 0 ? -d[i] : d[i], num, l2);
                    off = d[i] < 0 ? -off : off;
                    if (i == 0) r.nx = sat24(e1[i] + off);
                    else if (i == 1) r.ny = sat24(e1[i] + off);
                    else r.nz = sat24(e1[i] + off);
                end
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // watchdog
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("== FAIL ==");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        answer_t got, exp_a;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = {rsp.satisfied, rsp.changed_var, rsp.new_x, rsp.new_y, rsp.new_z};
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %h", got);
            end
            else
            begin
                exp_a = pending_answers.pop_front();
                if (got !== exp_a)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: sat %b/%b var %0d/%0d x %h/%h y %h/%h z %h/%h",
                                 exp_a.sat, got.sat, exp_a.cvar, got.cvar, exp_a.nx, got.nx,
                                 exp_a.ny, got.ny, exp_a.nz, got.nz);
                end
            end
        end
    end

    // sink ready with random stalls
    initial
    begin
        int g;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_gaps)
            begin
                g = gap_len();
                if (g > 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                rsp.ready <= 1'b1;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    task automatic send_query(query_t q, bit known, answer_t a);
        answer_t pred;
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        {req.operation, req.end1_x, req.end1_y, req.end1_z, req.end2_x, req.end2_y,
         req.end2_z, req.point_x, req.point_y, req.point_z} <= q;
        req.valid <= 1'b1;
        pred = solve_query(q);
        if (known && pred !== a)
        begin
            mismatches++;
            if (mismatches <= 10) $display("table row disagrees with predictor: %h", q);
        end
        pending_answers.push_back(pred);
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_epsilon(logic [EPW-1:0] v);
        cfg.data <= v;
        cfg.valid <= 1'b1;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        eps_model = v;
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(0, 8191)) - 4096);
            2: return ($urandom_range(0, 1)) ? 24'sh7fffff : 24'sh800000;
            default: return coord_t'(int'($urandom_range(0, 255)) - 128);
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        int m;
        m = $urandom_range(0, 9);
        m = (m < 3) ? 0 : (m < 6) ? 1 : (m < 7) ? 2 : 3;
        q.op = $urandom_range(0, 9) == 0 ? OP_NONE : 2'($urandom_range(0, 2));
        q.e1x = rand_coord(m); q.e1y = rand_coord(m); q.e1z = rand_coord(m);
        q.e2x = rand_coord(m); q.e2y = rand_coord(m); q.e2z = rand_coord(m);
        q.px = rand_coord(m); q.py = rand_coord(m); q.pz = rand_coord(m);
        if ($urandom_range(0, 15) == 0)
        begin
            q.e2x = q.e1x; q.e2y = q.e1y; q.e2z = q.e1z;
        end
        return q;
    endfunction

    localparam coord_t MAXC = 24'sh7fffff;
    localparam coord_t MINC = 24'sh800000;
    localparam coord_t ONE  = 24'sh001000;

    row_t table_rows[$];

    function automatic row_t mk(query_t q, bit known, answer_t a);
        row_t r;
        r.q = q; r.known = known; r.a = a;
        return r;
    endfunction

    initial
    begin
        answer_t fail_a;
        query_t q;
        rst_n = 1'b0;
        req.valid = 1'b0;
        {req.operation, req.end1_x, req.end1_y, req.end1_z, req.end2_x, req.end2_y,
         req.end2_z, req.point_x, req.point_y, req.point_z} = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        out_gaps = 1'b0;
        eps_model = EPS_RESET;
        fail_a = '0;

        table_rows.push_back(mk({OP_NONE, {9{MAXC}}}, 1, fail_a));
        table_rows.push_back(mk({OP_NONE, {9{MINC}}}, 1, fail_a));
        // equal lengths fail
        table_rows.push_back(mk({OP_END1, 24'sd0, 24'sd0, 24'sd0, ONE, 24'sd0, 24'sd0,
                                 -ONE, 24'sd0, 24'sd0}, 1, fail_a));
        table_rows.push_back(mk({OP_END2, 24'sd0, 24'sd0, 24'sd0, ONE, 24'sd0, 24'sd0,
                                 24'sd0, 24'sd0, 24'sd0}, 1, fail_a));
        table_rows.push_back(mk({OP_END1, 24'sd0, 24'sd0, 24'sd0, ONE, 24'sd0, 24'sd0,
                                 MAXC, MINC, MAXC}, 1, {1'b1, OP_END1, MAXC, MINC, MAXC}));
        table_rows.push_back(mk({OP_END2, MINC, MINC, MINC, MAXC, MAXC, MAXC,
                                 MINC, MINC, MINC}, 1, fail_a));
        table_rows.push_back(mk({OP_END2, MINC, MINC, MINC, MINC, MINC, MINC,
                                 MAXC, MAXC, MAXC}, 1, {1'b1, OP_END2, MAXC, MAXC, MAXC}));
        // degenerate segment snaps to end2
        table_rows.push_back(mk({OP_POINT, ONE, ONE, ONE, ONE, ONE, ONE,
                                 MAXC, MINC, 24'sd5}, 1, {1'b1, OP_POINT, ONE, ONE, ONE}));
        // clamp to end1, to end2
        table_rows.push_back(mk({OP_POINT, 24'sd0, 24'sd0, 24'sd0, ONE, 24'sd0, 24'sd0,
                                 -ONE, ONE, 24'sd0}, 1, {1'b1, OP_POINT, 24'sd0, 24'sd0, 24'sd0}));
        table_rows.push_back(mk({OP_POINT, 24'sd0, 24'sd0, 24'sd0, ONE, 24'sd0, 24'sd0,
                                 MAXC, 24'sd0, 24'sd0}, 1, {1'b1, OP_POINT, ONE, 24'sd0, 24'sd0}));
        table_rows.push_back(mk({OP_POINT, MINC, MINC, MINC, MAXC, MAXC, MAXC,
                                 24'sd0, 24'sd0, 24'sd0}, 0, fail_a));
        table_rows.push_back(mk({OP_POINT, MAXC, MINC, MAXC, MINC, MAXC, MINC,
                                 24'sd7, -24'sd3, 24'sd1}, 0, fail_a));
        table_rows.push_back(mk({OP_POINT, 24'sd0, 24'sd0, 24'sd0, 24'sd3, 24'sd0, 24'sd0,
                                 24'sd1, 24'sd9, 24'sd0}, 0, fail_a));
        table_rows.push_back(mk({OP_POINT, 24'sd0, 24'sd0, 24'sd0, -24'sd3, 24'sd2, 24'sd1,
                                 -24'sd1, 24'sd0, -24'sd4}, 0, fail_a));
        table_rows.push_back(mk({OP_END1, MAXC, MAXC, MAXC, MINC, MINC, MINC,
                                 MINC, MINC, MINC}, 1, fail_a));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i]) send_query(table_rows[i].q, table_rows[i].known, table_rows[i].a);
        drain();

        out_gaps = 1'b1;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_epsilon('0);
                1: write_epsilon({EPW{1'b1}});
                2: write_epsilon(EPW'(1) << 24);
                3: write_epsilon(EPW'($urandom) << 12 | EPW'($urandom_range(0, 4095)));
                4: write_epsilon(EPW'(52'h5555555555555));
                default: write_epsilon(EPW'(52'haaaaaaaaaaaaa));
            endcase
            for (int n = 0; n < 250; n++)
            begin
                q = rand_query();
                send_query(q, 0, fail_a);
                if (ph == 2 && n == 100)
                begin
                    req.valid <= 1'b0;
                    while (pending_answers.size() != 0) @(posedge clk);
                end
            end
            drain();
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

@@ segment_point_constraint.f @@
+incdir+rtl
rtl/spc_pkg.sv
rtl/spc_if.sv
rtl/spc_divider.sv
rtl/segment_point_constraint.sv
rtl/spc_checker.sv
tb/sv/segment_point_constraint_tb.sv
